@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bfm_pkg.sv @@
// Package with the shared constants and types of the bitap fuzzy match scorer.
package bfm_pkg;

   localparam int PATTERN_MAX   = 63;
   localparam int ALPHABET_SIZE = 128;
   localparam int MASK_W        = PATTERN_MAX;
   localparam int ROW_W         = 64;
   localparam int IDX_W         = $clog2(ALPHABET_SIZE);
   localparam int LEN_W         = 6;
   localparam int SCORE_W       = 32;
   localparam int ADD_W         = 8;
   localparam int LEVEL_W       = 2;
   localparam int HITS_W        = 3;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   localparam logic [IDX_W-1:0] UPPER_FIRST = 7'd65;
   localparam logic [IDX_W-1:0] UPPER_LAST  = 7'd90;
   localparam logic [IDX_W-1:0] CASE_OFFSET = 7'd32;

   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

   localparam logic [ROW_W-1:0] ROW0_INIT = ~64'd1;
   localparam logic [ROW_W-1:0] ROW1_INIT = ~64'd1 << 1;
   localparam logic [ROW_W-1:0] ROW2_INIT = ~64'd1 << 2;

   typedef struct packed {
      logic               step;
      logic               first;
      logic [LEVEL_W-1:0] levels;
      logic [LEN_W-1:0]   pat_len;
   } srch_ctrl_type;

endpackage

@@ rtl/bfm_mask_ram.sv @@
// Character mask memory with a registered read and write-to-read forwarding.
`include "assert_macros.svh"

module bfm_mask_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [bfm_pkg::IDX_W-1:0]   rd_addr,
   input  logic                        wr_en,
   input  logic [bfm_pkg::IDX_W-1:0]   wr_addr,
   input  logic [bfm_pkg::MASK_W-1:0]  wr_data,
   output logic [bfm_pkg::MASK_W-1:0]  rd_data
);

   logic [bfm_pkg::MASK_W-1:0] mem [bfm_pkg::ALPHABET_SIZE];
   logic [bfm_pkg::MASK_W-1:0] rd_q_ff;
   logic [bfm_pkg::MASK_W-1:0] fwd_data_ff;
   logic                       fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

   `ASSERT_NEXT(a_fwd_data, clock, reset, rd_en && wr_en && (rd_addr == wr_addr), rd_data == $past(wr_data), "read of an entry written in the same cycle missed the new data")

endmodule

@@ rtl/bfm_search_core.sv @@
// Error rows and score accumulator of the bitap search.
`include "assert_macros.svh"

module bfm_search_core (
   input  logic                          clock,
   input  logic                          reset,
   input  bfm_pkg::srch_ctrl_type        ctrl,
   input  logic [bfm_pkg::ROW_W-1:0]     mask,
   output logic [bfm_pkg::SCORE_W-1:0]   score_next,
   output logic [bfm_pkg::HITS_W-1:0]    hits,
   output logic [bfm_pkg::ADD_W-1:0]     char_score
);

   logic [bfm_pkg::ROW_W-1:0]   row0_ff, row1_ff, row2_ff;
   logic [bfm_pkg::ROW_W-1:0]   row0_cur, row1_cur, row2_cur;
   logic [bfm_pkg::ROW_W-1:0]   row0_in, row1_in, row2_in;
   logic [bfm_pkg::SCORE_W-1:0] score_ff;
   logic [bfm_pkg::SCORE_W-1:0] score_cur;
   logic [bfm_pkg::ADD_W-1:0]   pen1, pen2, add;
   logic [bfm_pkg::SCORE_W:0]   sum;
   logic                        lvl1, lvl2;

   always_comb begin
      row0_cur  = ctrl.first ? bfm_pkg::ROW0_INIT : row0_ff;
      row1_cur  = ctrl.first ? bfm_pkg::ROW1_INIT : row1_ff;
      row2_cur  = ctrl.first ? bfm_pkg::ROW2_INIT : row2_ff;
      score_cur = ctrl.first ? '0 : score_ff;
      lvl1      = ctrl.levels >= 2'd1;
      lvl2      = ctrl.levels >= 2'd2;

      row0_in = (row0_cur | mask) << 1;
      row1_in = row1_cur;
      row2_in = row2_cur;
      if (lvl1) begin
         row1_in = ((row1_cur | mask) << 1) & row0_cur & (row0_in << 1) & (row0_cur << 1);
      end
      if (lvl2) begin
         row2_in = ((row2_cur | mask) << 1) & row1_cur & (row1_in << 1) & (row1_cur << 1);
      end

      hits[0] = !row0_in[ctrl.pat_len];
      hits[1] = lvl1 && !row1_in[ctrl.pat_len];
      hits[2] = lvl2 && !row2_in[ctrl.pat_len];

      pen1 = (ctrl.pat_len >= 6'd2) ? bfm_pkg::ADD_W'(ctrl.pat_len - 6'd2) : '0;
      pen2 = (ctrl.pat_len >= 6'd4) ? bfm_pkg::ADD_W'(ctrl.pat_len - 6'd4) : '0;
      add  = (hits[0] ? bfm_pkg::ADD_W'(ctrl.pat_len) : '0)
           + (hits[1] ? pen1 : '0)
           + (hits[2] ? pen2 : '0);

      sum        = {1'b0, score_cur} + (bfm_pkg::SCORE_W + 1)'(add);
      score_next = sum[bfm_pkg::SCORE_W] ? '1 : sum[bfm_pkg::SCORE_W-1:0];
      char_score = add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff  <= bfm_pkg::ROW0_INIT;
         row1_ff  <= bfm_pkg::ROW1_INIT;
         row2_ff  <= bfm_pkg::ROW2_INIT;
         score_ff <= '0;
      end else if (ctrl.step) begin
         row0_ff  <= row0_in;
         row1_ff  <= row1_in;
         row2_ff  <= row2_in;
         score_ff <= score_next;
      end
   end

   `ASSERT_NEXT(a_score_mono, clock, reset, ctrl.step && !ctrl.first, score_ff >= $past(score_ff), "score went down without a search restart")
   `ASSERT_IMPLIES(a_hits_bound, clock, reset, ctrl.step && (ctrl.levels == 2'd0), hits[2:1] == 2'b00, "hit reported above the level bound")

endmodule

@@ rtl/bitap_fuzzy_match_scorer.sv @@
// Top level of the bitap fuzzy match scorer.
// The block takes one word per clock cycle unless a stalled result holds it back.
// An accepted character and its read of the character mask memory are registered, and
// the row update runs from that stage into the output register once it may advance, so
// the result word of a text character is presented from the output register. Pattern
// characters give no result word. A stalled result holds back the next word only once
// the output register is full and the update stage holds a text character.
`include "assert_macros.svh"

module bitap_fuzzy_match_scorer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [6:0]                     req_char_code,
   input  logic                           req_first,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_total_score,
   output logic [2:0]                     rsp_level_hits,
   output logic [7:0]                     rsp_char_score,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data
);

   logic                               accept;
   logic [bfm_pkg::IDX_W-1:0]          idx_in;
   logic                               s1_valid_ff, s1_kind_ff, s1_first_ff;
   logic [bfm_pkg::IDX_W-1:0]          s1_idx_ff;
   logic                               s1_adv, pat_adv, text_adv;
   logic [bfm_pkg::ALPHABET_SIZE-1:0]  valid_ff, valid_in;
   logic [bfm_pkg::LEN_W-1:0]          pat_len_ff, len_eff;
   logic [1:0]                         dist_limit_ff, dmax;
   logic                               valid_sel, can_wr, wr_en, len_grow;
   logic [bfm_pkg::MASK_W-1:0]         ram_data, base, wr_data;
   logic [bfm_pkg::ROW_W-1:0]          text_mask;
   bfm_pkg::srch_ctrl_type             ctrl;
   logic [bfm_pkg::SCORE_W-1:0]        score_next;
   logic [bfm_pkg::HITS_W-1:0]         hits;
   logic [bfm_pkg::ADD_W-1:0]          char_score;
   logic                               rsp_valid_ff;
   logic [bfm_pkg::SCORE_W-1:0]        rsp_score_ff;
   logic [bfm_pkg::HITS_W-1:0]         rsp_hits_ff;
   logic [bfm_pkg::ADD_W-1:0]          rsp_add_ff;

   always_comb begin
      idx_in = req_char_code;
      if (req_char_code >= bfm_pkg::UPPER_FIRST && req_char_code <= bfm_pkg::UPPER_LAST) begin
         idx_in = req_char_code + bfm_pkg::CASE_OFFSET;
      end
   end

   assign s1_adv    = (s1_kind_ff == bfm_pkg::KIND_PATTERN) || !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign pat_adv   = s1_valid_ff && (s1_kind_ff == bfm_pkg::KIND_PATTERN);
   assign text_adv  = s1_valid_ff && (s1_kind_ff == bfm_pkg::KIND_TEXT) && s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_kind;
         s1_first_ff <= req_first;
         s1_idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_limit_ff <= 2'd1;
      end else if (csr_wr_en) begin
         dist_limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      len_eff   = (pat_adv && s1_first_ff) ? '0 : pat_len_ff;
      can_wr    = len_eff != bfm_pkg::LEN_FULL;
      valid_sel = valid_ff[s1_idx_ff] && !(pat_adv && s1_first_ff);
      base      = valid_sel ? ram_data : '1;
      wr_en     = pat_adv && can_wr;
      len_grow  = pat_adv && !s1_first_ff && can_wr;
      wr_data   = base & ~(bfm_pkg::MASK_W'(1) << len_eff);
      text_mask = valid_sel ? {1'b1, ram_data} : '1;
      dmax      = (dist_limit_ff == 2'd3) ? 2'd2 : dist_limit_ff;
      ctrl.step    = text_adv;
      ctrl.first   = s1_first_ff;
      ctrl.pat_len = pat_len_ff;
      ctrl.levels  = ({4'b0, dmax} > pat_len_ff) ? pat_len_ff[1:0] : dmax;
   end

   always_comb begin
      valid_in = valid_ff;
      if (pat_adv && s1_first_ff) begin
         valid_in = '0;
      end
      if (wr_en) begin
         valid_in[s1_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         pat_len_ff <= '0;
      end else if (pat_adv) begin
         valid_ff <= valid_in;
         if (can_wr) begin
            pat_len_ff <= len_eff + 6'd1;
         end else begin
            pat_len_ff <= len_eff;
         end
      end
   end

   bfm_mask_ram u_mask_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (idx_in),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_data),
      .rd_data (ram_data)
   );

   bfm_search_core u_search_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .mask       (text_mask),
      .score_next (score_next),
      .hits       (hits),
      .char_score (char_score)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (text_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (text_adv) begin
         rsp_score_ff <= score_next;
         rsp_hits_ff  <= hits;
         rsp_add_ff   <= char_score;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_score = rsp_score_ff;
   assign rsp_level_hits  = rsp_hits_ff;
   assign rsp_char_score  = rsp_add_ff;

   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(text_adv), "stray result word")
   `ASSERT_NEXT(a_len_step, clock, reset, len_grow, pat_len_ff == $past(pat_len_ff) + 6'd1, "length stuck")
   `ASSERT_NEXT(a_valid_set, clock, reset, wr_en, valid_ff[$past(s1_idx_ff)], "entry not marked valid")

endmodule
